@@ design/lkc_pkg.sv @@
// Package for the learned key-combination hold reset block.
// Holds the phase type, the word and configuration structs and register indexes.
// No dependencies; every other design file refers to it by scoped names.
package lkc_pkg;

    // Phase of the block as reported in every result word.
    typedef enum logic [1:0] {
        PH_CAPTURE   = 2'd0,
        PH_ARMED     = 2'd1,
        PH_TRIGGERED = 2'd2
    } t_phase;

    // Configuration register indexes.
    localparam logic [0:0] REG_HOLD_SECONDS    = 1'b0;
    localparam logic [0:0] REG_CAPTURE_TIMEOUT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [3:0]  HOLD_SECONDS_RST = 4'd5;
    localparam logic [13:0] HOLD_MS_RST      = 14'd5000;
    localparam logic [15:0] TIMEOUT_MS_RST   = 16'd1200;

    // Milliseconds in one second, and the span covered by the second decoder.
    localparam int MS_PER_SEC  = 1000;
    localparam int SEC_SPAN_MS = 16000;

    // One input word after unpacking.
    typedef struct packed {
        logic        action;
        logic [6:0]  scancode;
        logic        key_up;
        logic [31:0] now_ms;
    } t_item;

    // Configuration as seen by the engine; hold_ms is hold_seconds times 1000.
    typedef struct packed {
        logic [3:0]  hold_seconds;
        logic [13:0] hold_ms;
        logic [15:0] timeout_ms;
    } t_cfg;

    // One result word.
    typedef struct packed {
        t_phase      phase;
        logic        capture_end;
        logic [7:0]  combo_key_count;
        logic        progress_valid;
        logic [3:0]  progress_seconds;
        logic        reboot;
    } t_result;

endpackage

@@ design/lkc_cfg_regs.sv @@
// Configuration registers of the key-combination hold reset block.
// Depends on lkc_pkg for the register indexes, reset values and the t_cfg struct.
module lkc_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    output lkc_pkg::t_cfg    o_cfg
);

    logic [3:0]  r_hold_seconds;
    logic [13:0] r_hold_ms;
    logic [15:0] r_timeout_ms;
    logic [13:0] n_hold_ms;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Precompute the hold time in milliseconds so the engine only compares.
    assign n_hold_ms = 14'(i_cfg_data[3:0]) * 14'(lkc_pkg::MS_PER_SEC);

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_seconds <= lkc_pkg::HOLD_SECONDS_RST;
            r_hold_ms      <= lkc_pkg::HOLD_MS_RST;
            r_timeout_ms   <= lkc_pkg::TIMEOUT_MS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lkc_pkg::REG_HOLD_SECONDS: begin
                    r_hold_seconds <= i_cfg_data[3:0];
                    r_hold_ms      <= n_hold_ms;
                end
                lkc_pkg::REG_CAPTURE_TIMEOUT: begin
                    r_timeout_ms <= i_cfg_data;
                end
            endcase
        end
    end

    assign o_cfg.hold_seconds = r_hold_seconds;
    assign o_cfg.hold_ms      = r_hold_ms;
    assign o_cfg.timeout_ms   = r_timeout_ms;

endmodule

@@ design/lkc_engine.sv @@
// State and per-word logic of the key-combination hold reset block.
// Depends on lkc_pkg for t_phase, t_item, t_cfg and t_result.
module lkc_engine #(
    parameter int KEY_CODES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  lkc_pkg::t_item    i_item,
    input  lkc_pkg::t_cfg     i_cfg,
    output lkc_pkg::t_result  o_result
);

    localparam int IDX_W = $clog2(KEY_CODES);
    localparam int CNT_W = $clog2(KEY_CODES + 1);

    // Mode and key state.
    lkc_pkg::t_phase        r_mode, n_mode;
    logic [KEY_CODES-1:0]   r_pressed, n_pressed;
    logic [KEY_CODES-1:0]   r_combo, n_combo;
    logic [KEY_CODES-1:0]   r_down, n_down;
    logic [CNT_W-1:0]       r_combo_cnt, n_combo_cnt;
    logic [CNT_W-1:0]       r_pressed_cnt, n_pressed_cnt;
    logic [CNT_W-1:0]       r_missing, n_missing;
    logic                   r_key_seen, n_key_seen;
    logic [31:0]            r_last_key_time, n_last_key_time;
    logic                   r_hold_active, n_hold_active;
    logic [31:0]            r_hold_start, n_hold_start;
    logic [3:0]             r_last_sec, n_last_sec;

    // Decoded word.
    logic [IDX_W-1:0]       key_idx;
    logic                   in_range;
    logic                   is_key;
    logic                   pressed_bit;
    logic                   combo_bit;
    logic                   down_bit;

    // Capture and hold conditions.
    logic [31:0]            idle_ms;
    logic                   capture_done;
    logic [31:0]            elapsed;
    logic [3:0]             sec;
    logic                   sec_in_span;
    logic                   tick_report;
    logic                   tick_trigger;
    logic                   report;
    logic                   trigger;

    // Key index and the bits it selects.
    assign key_idx     = IDX_W'(i_item.scancode);
    assign in_range    = 9'(i_item.scancode) < 9'(KEY_CODES);
    assign is_key      = !i_item.action;
    assign pressed_bit = r_pressed[key_idx];
    assign combo_bit   = r_combo[key_idx];
    assign down_bit    = r_down[key_idx];

    // Capture path: learn the combination and detect its end.
    always_comb begin
        n_pressed       = r_pressed;
        n_combo         = r_combo;
        n_combo_cnt     = r_combo_cnt;
        n_pressed_cnt   = r_pressed_cnt;
        n_key_seen      = r_key_seen;
        n_last_key_time = r_last_key_time;
        if (r_mode == lkc_pkg::PH_CAPTURE && is_key && in_range
            && i_item.scancode != 7'd0) begin
            if (!i_item.key_up) begin
                // A repeated make of a key already down is ignored.
                if (!pressed_bit) begin
                    n_pressed[key_idx] = 1'b1;
                    n_pressed_cnt      = r_pressed_cnt + CNT_W'(1);
                    if (!combo_bit) begin
                        n_combo[key_idx] = 1'b1;
                        n_combo_cnt      = r_combo_cnt + CNT_W'(1);
                    end
                    n_last_key_time = i_item.now_ms;
                    n_key_seen      = 1'b1;
                end
            end else begin
                if (pressed_bit) begin
                    n_pressed[key_idx] = 1'b0;
                    n_pressed_cnt      = r_pressed_cnt - CNT_W'(1);
                end
                n_last_key_time = i_item.now_ms;
                n_key_seen      = 1'b1;
            end
        end
        idle_ms      = i_item.now_ms - n_last_key_time;
        capture_done = n_key_seen && (n_combo_cnt != '0)
                       && ((n_pressed_cnt == '0) || (idle_ms > 32'(i_cfg.timeout_ms)));
    end

    // Whole seconds of the running hold; only needed below sixteen seconds.
    always_comb begin
        elapsed     = i_item.now_ms - r_hold_start;
        sec_in_span = (elapsed[31:14] == '0)
                      && (elapsed[13:0] < 14'(lkc_pkg::SEC_SPAN_MS));
        sec         = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (elapsed[13:0] >= 14'(k * lkc_pkg::MS_PER_SEC)) begin
                sec = 4'(k);
            end
        end
        tick_report  = sec_in_span && (sec != 4'd0) && (sec != r_last_sec)
                       && (sec < i_cfg.hold_seconds);
        tick_trigger = elapsed >= 32'(i_cfg.hold_ms);
    end

    // Armed path: track keys down and time the hold.
    always_comb begin
        n_down        = r_down;
        n_missing     = r_missing;
        n_hold_active = r_hold_active;
        n_hold_start  = r_hold_start;
        n_last_sec    = r_last_sec;
        report        = 1'b0;
        trigger       = 1'b0;
        if (r_mode == lkc_pkg::PH_CAPTURE) begin
            // Keys down are all clear at arming, so every combination key is missing.
            n_missing = n_combo_cnt;
        end else if (r_mode == lkc_pkg::PH_ARMED) begin
            if (is_key) begin
                if (in_range) begin
                    n_down[key_idx] = !i_item.key_up;
                    if (combo_bit && !i_item.key_up && !down_bit) begin
                        n_missing = r_missing - CNT_W'(1);
                    end else if (combo_bit && i_item.key_up && down_bit) begin
                        n_missing = r_missing + CNT_W'(1);
                    end
                    // Any release drops the running hold.
                    if (i_item.key_up) begin
                        n_hold_active = 1'b0;
                        n_last_sec    = 4'd0;
                    end
                end
            end else if (r_missing != '0) begin
                n_hold_active = 1'b0;
                n_last_sec    = 4'd0;
            end else if (!r_hold_active) begin
                // First tick with the whole combination down starts the hold.
                n_hold_active = 1'b1;
                n_hold_start  = i_item.now_ms;
                n_last_sec    = 4'd0;
            end else begin
                report  = tick_report;
                trigger = tick_trigger;
                if (tick_report) begin
                    n_last_sec = sec;
                end
            end
        end
    end

    // Next phase.
    always_comb begin
        unique case (r_mode)
            lkc_pkg::PH_CAPTURE: begin
                n_mode = capture_done ? lkc_pkg::PH_ARMED : lkc_pkg::PH_CAPTURE;
            end
            lkc_pkg::PH_ARMED: begin
                n_mode = trigger ? lkc_pkg::PH_TRIGGERED : lkc_pkg::PH_ARMED;
            end
            lkc_pkg::PH_TRIGGERED: begin
                n_mode = lkc_pkg::PH_TRIGGERED;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // Result word for the current input word.
    always_comb begin
        o_result.phase            = n_mode;
        o_result.capture_end      = (r_mode == lkc_pkg::PH_CAPTURE) && capture_done;
        o_result.combo_key_count  = 8'(n_combo_cnt);
        o_result.progress_valid   = report;
        o_result.progress_seconds = report ? sec : 4'd0;
        o_result.reboot           = trigger;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= lkc_pkg::PH_CAPTURE;
            r_pressed     <= '0;
            r_combo       <= '0;
            r_down        <= '0;
            r_combo_cnt   <= '0;
            r_pressed_cnt <= '0;
            r_missing     <= '0;
            r_key_seen    <= 1'b0;
            r_hold_active <= 1'b0;
            r_last_sec    <= 4'd0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_pressed     <= n_pressed;
            r_combo       <= n_combo;
            r_down        <= n_down;
            r_combo_cnt   <= n_combo_cnt;
            r_pressed_cnt <= n_pressed_cnt;
            r_missing     <= n_missing;
            r_key_seen    <= n_key_seen;
            r_hold_active <= n_hold_active;
            r_last_sec    <= n_last_sec;
        end
    end

    // Time stamps; each is read only while its flag is set.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_last_key_time <= n_last_key_time;
            r_hold_start    <= n_hold_start;
        end
    end

    // The triggered phase is never left until reset.
    a_trigger_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == lkc_pkg::PH_TRIGGERED |=> r_mode == lkc_pkg::PH_TRIGGERED)
        else $error("triggered phase was left");

    // The learned combination is frozen once capture has ended.
    a_combo_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != lkc_pkg::PH_CAPTURE |=> $stable(r_combo_cnt) && $stable(r_combo))
        else $error("combination changed after capture");

    // A running hold means every combination key is down.
    a_hold_needs_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_active |-> r_missing == '0)
        else $error("hold running with a combination key up");

    // Keys down are only tracked after capture, and the missing count is bounded.
    a_capture_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == lkc_pkg::PH_CAPTURE |-> r_down == '0 && r_missing <= r_combo_cnt)
        else $error("armed state present during capture");

endmodule

@@ design/learned_key_combo_hold_reset_unit.sv @@
// Top level of the learned key-combination hold reset block.
// Depends on lkc_pkg, lkc_cfg_regs and lkc_engine.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata key word, tuser action
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata result word
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One word is accepted per cycle when the output side keeps up. The input register takes
// the word at its accepting edge, and the combinational key and hold logic loads the result
// register from it once that register is free or being read, and the result word is offered there.
// Reset is synchronous and active low, with no clearing pass.
// A stalled output holds its word while the input register still takes one more word.
// Configuration writes are taken in every cycle.
module learned_key_combo_hold_reset_unit #(
    parameter int KEY_CODES = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Key and tick words.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // scancode[6:0], key_up[7], now_ms[39:8]
    input  logic         s_axis_tuser,   // action[0]
    // Result words.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // phase[1:0], capture_end[2],
                                         // combo_key_count[10:3], progress_valid[11],
                                         // progress_seconds[15:12], reboot[16], zero[23:17]
    // Configuration writes.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    logic               r_in_valid;
    lkc_pkg::t_item     r_in_item;
    logic               r_out_valid;
    lkc_pkg::t_result   r_out;
    lkc_pkg::t_result   n_result;
    lkc_pkg::t_cfg      cfg;
    logic               in_accept;
    logic               out_accept;
    logic               fire;

    // Pipeline handshake.
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = r_out_valid && m_axis_tready;

    lkc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lkc_engine #(
        .KEY_CODES (KEY_CODES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (n_result)
    );

    // Valid flags of the input and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input word register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item.action   <= s_axis_tuser;
            r_in_item.scancode <= s_axis_tdata[6:0];
            r_in_item.key_up   <= s_axis_tdata[7];
            r_in_item.now_ms   <= s_axis_tdata[39:8];
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.reboot, r_out.progress_seconds, r_out.progress_valid,
                            r_out.combo_key_count, r_out.capture_end, r_out.phase};

endmodule

@@ dv/learned_key_combo_hold_reset_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for learned_key_combo_hold_reset_unit: key capture, armed hold timing,
// second reports and the latched reboot, under random stalls on both streams.
// Depends on lkc_pkg and the design files only.

module learned_key_combo_hold_reset_unit_tb;

    // Tracks the key and hold state, predicts one result word per accepted word and
    // compares the result stream against those predictions in order.
    class combo_hold_checker;
        lkc_pkg::t_phase  mode;
        bit [127:0]       capture_down;
        bit [127:0]       combo;
        bit [127:0]       keys_down;
        bit               key_seen;
        bit [31:0]        last_key_ms;
        bit               hold_on;
        bit [31:0]        hold_t0;
        bit [3:0]         last_sec;
        bit [3:0]         hold_s;
        bit [15:0]        timeout_ms;
        lkc_pkg::t_result awaited_results[$];
        int               mismatches;
        int               items_taken;
        int               words_seen;
        int               progress_reports;
        int               captures;
        int               reboots;

        function new();
            mode         = lkc_pkg::PH_CAPTURE;
            capture_down = '0;
            combo        = '0;
            keys_down    = '0;
            key_seen     = 1'b0;
            last_key_ms  = '0;
            hold_on      = 1'b0;
            hold_t0      = '0;
            last_sec     = '0;
            hold_s       = lkc_pkg::HOLD_SECONDS_RST;
            timeout_ms   = lkc_pkg::TIMEOUT_MS_RST;
            mismatches   = 0;
            items_taken  = 0;
            words_seen   = 0;
            progress_reports = 0;
            captures     = 0;
            reboots      = 0;
        endfunction

        function void drop_hold();
            hold_on  = 1'b0;
            hold_t0  = '0;
            last_sec = '0;
        endfunction

        // True when a tick at this time would complete the hold and latch the reboot.
        function bit would_trigger(bit [31:0] now);
            bit [31:0] elapsed;
            elapsed = now - hold_t0;
            return mode == lkc_pkg::PH_ARMED && hold_on && (combo & ~keys_down) == '0
                   && elapsed >= 32'(hold_s) * 32'(lkc_pkg::MS_PER_SEC);
        endfunction

        function lkc_pkg::t_result next_result(lkc_pkg::t_item it);
            lkc_pkg::t_result r;
            bit [31:0]        idle;
            bit [31:0]        elapsed;
            bit [31:0]        sec;
            r = '0;
            if (mode == lkc_pkg::PH_CAPTURE) begin
                // Code zero never joins the combination; a repeated make changes nothing.
                if (!it.action && it.scancode != 7'd0) begin
                    if (!it.key_up && !capture_down[it.scancode]) begin
                        capture_down[it.scancode] = 1'b1;
                        combo[it.scancode]        = 1'b1;
                        last_key_ms               = it.now_ms;
                        key_seen                  = 1'b1;
                    end else if (it.key_up) begin
                        capture_down[it.scancode] = 1'b0;
                        last_key_ms               = it.now_ms;
                        key_seen                  = 1'b1;
                    end
                end
                // Capture ends once everything is released or the idle time runs out.
                if (key_seen && combo != '0) begin
                    idle = it.now_ms - last_key_ms;
                    if (capture_down == '0 || idle > 32'(timeout_ms)) begin
                        mode          = lkc_pkg::PH_ARMED;
                        r.capture_end = 1'b1;
                    end
                end
            end else if (mode == lkc_pkg::PH_ARMED) begin
                if (!it.action) begin
                    // Every release drops the running hold, combination key or not.
                    keys_down[it.scancode] = !it.key_up;
                    if (it.key_up) drop_hold();
                end else if ((combo & ~keys_down) != '0) begin
                    drop_hold();
                end else if (!hold_on) begin
                    hold_on  = 1'b1;
                    hold_t0  = it.now_ms;
                    last_sec = '0;
                end else begin
                    elapsed = it.now_ms - hold_t0;
                    sec     = elapsed / 32'(lkc_pkg::MS_PER_SEC);
                    if (sec != 0 && sec != 32'(last_sec) && sec < 32'(hold_s)) begin
                        last_sec           = sec[3:0];
                        r.progress_valid   = 1'b1;
                        r.progress_seconds = sec[3:0];
                    end
                    if (elapsed >= 32'(hold_s) * 32'(lkc_pkg::MS_PER_SEC)) begin
                        mode     = lkc_pkg::PH_TRIGGERED;
                        r.reboot = 1'b1;
                    end
                end
            end
            r.phase           = mode;
            r.combo_key_count = 8'($countones(combo));
            return r;
        endfunction

        function void note_item(lkc_pkg::t_item it);
            lkc_pkg::t_result r;
            r = next_result(it);
            items_taken++;
            progress_reports += r.progress_valid;
            captures         += r.capture_end;
            reboots          += r.reboot;
            awaited_results.push_back(r);
        endfunction

        function void check_word(logic [23:0] w);
            lkc_pkg::t_result want;
            lkc_pkg::t_result got;
            logic [6:0]       pad;
            got = {w[1:0], w[2], w[10:3], w[11], w[15:12], w[16]};
            pad = w[23:17];
            words_seen++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: result word %h arrived with nothing outstanding", w);
                return;
            end
            want = awaited_results.pop_front();
            if (got !== want || pad !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"error: result %0d expected phase %0d cap %0b count %0d ",
                              "prog %0b/%0d reboot %0b, got phase %0d cap %0b count %0d ",
                              "prog %0b/%0d reboot %0b pad %h"},
                             words_seen, want.phase, want.capture_end,
                             want.combo_key_count, want.progress_valid,
                             want.progress_seconds, want.reboot, got.phase,
                             got.capture_end, got.combo_key_count, got.progress_valid,
                             got.progress_seconds, got.reboot, pad);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    combo_hold_checker tracker;
    bit                steady;
    bit                reboot_allowed;
    bit [31:0]         clock_ms;
    int                items_sent;
    bit [6:0]          combo_codes[$];

    learned_key_combo_hold_reset_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side stalls at random except during the steady stretch.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 30);
        end
    end

    // Every accepted result word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) tracker.check_word(m_axis_tdata);
    end

    // Sends one word; called at a falling edge and returns at one after acceptance.
    task automatic send_item(bit act, bit [6:0] code, bit brk);
        lkc_pkg::t_item it;
        it = '{action: act, scancode: code, key_up: brk, now_ms: clock_ms};
        while (!steady && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.now_ms, it.key_up, it.scancode};
        s_axis_tuser  <= it.action;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_key(bit [6:0] code, bit brk);
        send_item(1'b0, code, brk);
    endtask

    function automatic bit [6:0] pick_combo_key();
        return combo_codes[$urandom_range(0, combo_codes.size() - 1)];
    endfunction

    // Any key outside the combination, code zero included.
    function automatic bit [6:0] stray_key();
        bit [6:0] c;
        do c = 7'($urandom_range(0, 127)); while (tracker.combo[c]);
        return c;
    endfunction

    // Until the finale, a tick that would complete the hold becomes a release instead.
    task automatic send_tick();
        if (!reboot_allowed && tracker.would_trigger(clock_ms))
            send_key(pick_combo_key(), 1'b1);
        else
            send_item(1'b1, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(logic [0:0] index, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == lkc_pkg::REG_HOLD_SECONDS) tracker.hold_s = value[3:0];
        else tracker.timeout_ms = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Holds the input back until every predicted word has come out.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (tracker.awaited_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Press the combination, hold it over a run of ticks, then let go of one key.
    task automatic hold_episode();
        int        n_ticks;
        int        first;
        bit [31:0] span;
        first = $urandom_range(0, combo_codes.size() - 1);
        foreach (combo_codes[i]) begin
            if ($urandom_range(0, 9) == 0) send_key(stray_key(), 1'b0);
            // Now and then a key of the combination is left out.
            if ($urandom_range(0, 19) != 0) begin
                clock_ms += $urandom_range(0, 60);
                send_key(combo_codes[(first + i) % combo_codes.size()], 1'b0);
            end
        end
        n_ticks = $urandom_range(1, 24);
        span    = $urandom_range(0, 1000 * int'(tracker.hold_s) + 500);
        repeat (n_ticks) begin
            clock_ms += span / n_ticks + $urandom_range(0, 30);
            send_tick();
            if ($urandom_range(0, 7) == 0) send_key(stray_key(), 1'b0);
        end
        clock_ms += $urandom_range(0, 60);
        send_key(($urandom_range(0, 3) != 0) ? pick_combo_key() : stray_key(), 1'b1);
    endtask

    // Unstructured key or tick word; large jumps move the upper timestamp bits.
    task automatic noise_item();
        if ($urandom_range(0, 19) == 0) clock_ms += $urandom();
        else clock_ms += $urandom_range(0, 400);
        if ($urandom_range(0, 1)) send_tick();
        else send_key(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    endtask

    // Stimulus.
    initial begin
        bit [6:0]  c;
        bit [31:0] t0;
        int        n_extra;
        int        phase_end;
        tracker        = new();
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        steady         = 1'b0;
        reboot_allowed = 1'b0;
        items_sent     = 0;
        clock_ms       = 32'hFFFF_FF00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(lkc_pkg::REG_HOLD_SECONDS, 16'd15);
        write_reg(lkc_pkg::REG_CAPTURE_TIMEOUT, 16'hFFFF);

        // Capture: a tick before any key, code zero, a repeated make, idle exactly at the limit.
        send_tick();
        send_key(7'd0, 1'b0);
        send_key(7'd0, 1'b1);
        clock_ms += 1;
        send_key(7'd127, 1'b0);
        combo_codes.push_back(7'd127);
        clock_ms += 3;
        send_key(7'd127, 1'b0);
        n_extra = $urandom_range(1, 3);
        repeat (n_extra) begin
            do c = stray_key(); while (c == 7'd0);
            clock_ms += 2;
            send_key(c, 1'b0);
            combo_codes.push_back(c);
        end
        clock_ms = tracker.last_key_ms + 32'd65535;
        send_tick();

        // Zero timeout: zero idle keeps capturing, then capture ends one way or the other.
        wait_for_results();
        write_reg(lkc_pkg::REG_CAPTURE_TIMEOUT, 16'd0);
        clock_ms += 10;
        send_key(7'd127, 1'b1);
        send_tick();
        send_key(7'd127, 1'b0);
        if ($urandom_range(0, 1)) begin
            clock_ms += 1;
            send_tick();
        end else begin
            foreach (combo_codes[i]) begin
                clock_ms += $urandom_range(1, 300);
                send_key(combo_codes[i], 1'b1);
            end
        end
        wait_for_results();
        write_reg(lkc_pkg::REG_CAPTURE_TIMEOUT, 16'($urandom_range(1, 65534)));

        // Armed: hold start, second reports, releases of code zero and of outside keys.
        foreach (combo_codes[i]) begin
            clock_ms += 5;
            send_key(combo_codes[i], 1'b0);
        end
        clock_ms += 20;
        send_tick();
        t0       = clock_ms;
        clock_ms = t0 + 32'd1000;
        send_tick();
        clock_ms = t0 + 32'd1999;
        send_tick();
        send_key(7'd0, 1'b0);
        send_key(7'd0, 1'b1);
        clock_ms += 100;
        send_tick();
        t0       = clock_ms;
        clock_ms = t0 + 32'd14999;
        send_tick();
        send_key(stray_key(), 1'b1);
        clock_ms += 10;
        send_tick();
        send_key(combo_codes[0], 1'b1);
        clock_ms += 10;
        send_tick();
        send_key(combo_codes[0], 1'b0);

        // Random hold episodes and noise under several hold settings.
        for (int p = 0; p < 4; p++) begin
            wait_for_results();
            case (p)
                0: write_reg(lkc_pkg::REG_HOLD_SECONDS, 16'd15);
                1: write_reg(lkc_pkg::REG_HOLD_SECONDS, 16'($urandom_range(2, 14)));
                2: write_reg(lkc_pkg::REG_HOLD_SECONDS, 16'd1);
                default: write_reg(lkc_pkg::REG_HOLD_SECONDS, 16'($urandom_range(1, 15)));
            endcase
            write_reg(lkc_pkg::REG_CAPTURE_TIMEOUT, 16'($urandom_range(0, 65535)));
            steady    = (p == 1);
            phase_end = items_sent + 240;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 70) hold_episode();
                else repeat ($urandom_range(1, 4)) noise_item();
            end
        end
        steady = 1'b0;

        // Zero hold seconds: the second tick of the hold latches the reboot for good.
        wait_for_results();
        write_reg(lkc_pkg::REG_HOLD_SECONDS, 16'd0);
        reboot_allowed = 1'b1;
        send_key(stray_key(), 1'b1);
        foreach (combo_codes[i]) begin
            clock_ms += 5;
            send_key(combo_codes[i], 1'b0);
        end
        clock_ms += 50;
        send_tick();
        send_tick();
        clock_ms += 1000;
        send_tick();
        send_key(combo_codes[0], 1'b1);
        send_key(stray_key(), 1'b0);

        wait_for_results();
        repeat (6) @(negedge i_clk);
        if (tracker.awaited_results.size() != 0) begin
            $display("error: %0d result words never arrived", tracker.awaited_results.size());
            tracker.mismatches += tracker.awaited_results.size();
        end
        $display("Run covered %0d key and tick words and %0d result words under %0d-key combo.",
                 tracker.items_taken, tracker.words_seen, combo_codes.size());
        $display("Captures %0d, second reports %0d, reboots %0d, mismatches %0d.",
                 tracker.captures, tracker.progress_reports, tracker.reboots,
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/lkc_pkg.sv
design/lkc_cfg_regs.sv
design/lkc_engine.sv
design/learned_key_combo_hold_reset_unit.sv
dv/learned_key_combo_hold_reset_unit_tb.sv
